/* rtl/cbd_pkg.sv */
// Shared types and constants for the chaff block deframer.
package cbd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 16;
    localparam int unsigned HoldW   = 24;
    localparam int unsigned StatusW = 2;

    // Bit of the flag byte that carries FIN.
    localparam logic [ByteW-1:0] FinMask = 8'h01;

    typedef enum logic [StatusW-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_FIN_EARLY = 2'd2
    } status_t;

    typedef struct packed {
        logic             data_valid;
        logic [ByteW-1:0] data_byte;
        logic             block_done;
        logic             fin;
        status_t          status;
    } result_t;

endpackage

/* rtl/cbd_parser.sv */
// Block parser: header, data, chaff, flag and discard phases, one byte per accepted word.
module cbd_parser
    import cbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [ByteW-1:0] in_byte,
    input  logic             in_last,
    output logic             res_valid,
    output result_t          res
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DATA    = 3'd1,
        PH_CHAFF   = 3'd2,
        PH_FLAG    = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        header_count_reg, header_count_next;
    logic [HoldW-1:0]  header_hold_reg, header_hold_next;
    logic [LenW-1:0]   data_left_reg, data_left_next;
    logic [LenW-1:0]   chaff_left_reg, chaff_left_next;
    logic [LenW-1:0]   hdr_data_len;
    logic [LenW-1:0]   hdr_chaff_len;
    logic              fin_bit;

    assign hdr_data_len  = header_hold_reg[HoldW-1:ByteW];
    assign hdr_chaff_len = {header_hold_reg[ByteW-1:0], in_byte};
    assign fin_bit       = |(in_byte & FinMask);

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        header_hold_next  = header_hold_reg;
        data_left_next    = data_left_reg;
        chaff_left_next   = chaff_left_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.status        = STATUS_OK;

        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg != 2'd3)
                    begin
                        header_hold_next  = {header_hold_reg[HoldW-ByteW-1:0], in_byte};
                        header_count_next = header_count_reg + 2'd1;
                    end
                    else
                    begin
                        data_left_next    = hdr_data_len;
                        chaff_left_next   = hdr_chaff_len;
                        header_count_next = 2'd0;
                        header_hold_next  = '0;
                        if (hdr_data_len != '0)
                            phase_next = PH_DATA;
                        else if (hdr_chaff_len != '0)
                            phase_next = PH_CHAFF;
                        else
                            phase_next = PH_FLAG;
                    end
                    if (in_last)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_SHORT;
                    end
                end
                PH_DATA:
                begin
                    data_left_next = data_left_reg - LenW'(1);
                    if (data_left_reg == LenW'(1))
                        phase_next = (chaff_left_reg != '0) ? PH_CHAFF : PH_FLAG;
                    res_valid      = 1'b1;
                    res.data_valid = 1'b1;
                    res.data_byte  = in_byte;
                    if (in_last)
                        res.status = STATUS_SHORT;
                end
                PH_CHAFF:
                begin
                    chaff_left_next = chaff_left_reg - LenW'(1);
                    if (chaff_left_reg == LenW'(1))
                        phase_next = PH_FLAG;
                    if (in_last)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_SHORT;
                    end
                end
                PH_FLAG:
                begin
                    res_valid      = 1'b1;
                    res.block_done = 1'b1;
                    res.fin        = fin_bit;
                    if (!in_last && fin_bit)
                    begin
                        res.status = STATUS_FIN_EARLY;
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    // Drop the rest of a failed buffer.
                end
            endcase

            // Any last byte restarts parsing; an early FIN moves to discard.
            if (in_last || (phase_next == PH_DISCARD))
            begin
                header_count_next = 2'd0;
                header_hold_next  = '0;
                data_left_next    = '0;
                chaff_left_next   = '0;
                if (in_last)
                    phase_next = PH_HEADER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= 2'd0;
            header_hold_reg  <= '0;
            data_left_reg    <= '0;
            chaff_left_reg   <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            header_hold_reg  <= header_hold_next;
            data_left_reg    <= data_left_next;
            chaff_left_reg   <= chaff_left_next;
        end
    end

endmodule

/* rtl/cbd_out_buf.sv */
// Result register with a skid slot, so one more result can be taken during a stall.
module cbd_out_buf
    import cbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // No push can arrive while the skid slot is full.
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/chaff_block_deframer_core.sv */
// Top level of the chaff block deframer: parser plus buffered result port.
//
//   channel | handshake           | fields
//   --------+---------------------+--------------------------------------------
//   input   | in_valid / in_ready | in_byte, in_last
//   output  | out_valid/out_ready | data_valid, data_byte, block_done, fin, status
//
// One word is taken per clock while in_ready is high; its result, if any, is registered in the result buffer.
// Parser state updates on the accepting edge, so no bubble is needed between words.
// Reset empties the result register and puts the parser at the start of a buffer.
// A word whose result arrives while a result is stalled fills the second result buffer entry;
// in_ready then stays low until the edge at which the first entry is taken.
module chaff_block_deframer_core
    import cbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ByteW-1:0]   in_byte,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               data_valid,
    output logic [ByteW-1:0]   data_byte,
    output logic               block_done,
    output logic               fin,
    output logic [StatusW-1:0] status
);

    logic    take;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign take = in_valid && in_ready;

    cbd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .res_valid (res_valid),
        .res       (res)
    );

    cbd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign data_valid = out_res.data_valid;
    assign data_byte  = out_res.data_byte;
    assign block_done = out_res.block_done;
    assign fin        = out_res.fin;
    assign status     = out_res.status;

endmodule

/* rtl/cbd_checker.sv */
// Port-level checks for the chaff block deframer, bound to the top level.
module cbd_checker
    import cbd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               data_valid,
    input logic [ByteW-1:0]   data_byte,
    input logic               block_done,
    input logic               fin,
    input logic [StatusW-1:0] status
);

    // A stalled result word must stay valid and hold its byte and status.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(status))
        else $error("result word changed while stalled");

    // A word is never both a data byte and a block end.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(data_valid && block_done))
        else $error("data and block end in one word");

    // FIN only travels with a block end.
    a_fin_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fin |-> block_done)
        else $error("FIN without block end");

    // An early FIN error always comes with the FIN that caused it.
    a_early_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FIN_EARLY) |-> block_done && fin)
        else $error("early FIN status without FIN");

    // Without a data byte the byte field is zero, and the status code is a known one.
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (data_valid || (data_byte == '0)) && (status != 2'd3))
        else $error("bad byte field or status code");

endmodule

bind chaff_block_deframer_core cbd_checker u_cbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .block_done (block_done),
    .fin        (fin),
    .status     (status)
);
